// ----- rtl/core/bsa_pkg.sv -----
// bsa_pkg: shared types, codes and field widths of the buffer slot allocator
// no dependencies; used by every module under rtl/core
package bsa_pkg;

  // default sizing of the pool and the time stamps
  localparam int unsigned SlotsDef    = 8;
  localparam int unsigned TimeBitsDef = 32;

  // fixed field widths of the request and result words
  localparam int unsigned ReqW      = 16;
  localparam int unsigned RefW      = 4;
  localparam int unsigned NowW      = 32;
  localparam int unsigned CntW      = 32;
  localparam int unsigned AgeW      = 32;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned GrantW    = 3;
  localparam int unsigned UsageW    = 4;
  localparam int unsigned LeakW     = 8;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 120;

  localparam logic [ReqW-1:0] MaxReqRst  = 16'd2048;
  localparam logic [AgeW-1:0] LeakAgeRst = 32'd30000;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RELEASED  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_REQ  = 1'b0,
    CFG_LEAK_AGE = 1'b1
  } cfg_idx_e;

  // per-word events from the slot table to the statistics
  typedef struct packed {
    logic alloc_ok;
    logic release_ok;
    logic refuse;
  } slot_evt_t;

endpackage

// ----- rtl/core/buffer_slot_allocator_top.sv -----
// buffer_slot_allocator_top: stream ports, config registers, input and result registers
// depends on bsa_pkg, bsa_slots, bsa_stats
// path: a word accepted into the input register moves on to the result register when that one is free or read
// throughput: one word per cycle while the output is not stalled; the slot table and counters update
// between the input register and the result register
// reset: all slots free, usage and counters zero, config back to 2048 and 30000 ms
module buffer_slot_allocator_top #(
  parameter int unsigned POOL_SLOTS = bsa_pkg::SlotsDef,
  parameter int unsigned TIME_BITS  = bsa_pkg::TimeBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bsa_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // request_bytes[15:0], slot_ref[19:16], now_ms[51:20], zero pad
  input  logic [bsa_pkg::InDataW-1:0]    s_axis_tdata_i,
  // func[0]
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // granted_slot[2:0], usage_now[6:3], usage_peak[10:7], alloc_count[42:11],
  // release_count[74:43], failure_count[106:75], healthy[107], leak_map[115:108], zero pad
  output logic [bsa_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // status[2:0]
  output logic [bsa_pkg::StatusW-1:0]    m_axis_tuser_o
);

  localparam int unsigned UseW = $clog2(POOL_SLOTS + 1);

  logic [bsa_pkg::ReqW-1:0] max_req_q;
  logic [bsa_pkg::AgeW-1:0] leak_age_q;

  logic                     in_valid_q;
  bsa_pkg::func_e           func_q;
  logic [bsa_pkg::ReqW-1:0] req_q;
  logic [bsa_pkg::RefW-1:0] ref_q;
  logic [bsa_pkg::NowW-1:0] now_q;

  logic advance, step, in_acc;

  bsa_pkg::status_e           status;
  logic [bsa_pkg::GrantW-1:0] granted;
  logic [bsa_pkg::LeakW-1:0]  leak_map;
  bsa_pkg::slot_evt_t         evt;
  logic [UseW-1:0]            used_d, peak_d;
  logic [bsa_pkg::CntW-1:0]   grants_d, returns_d, refusals_d;
  logic                       healthy;

  logic                          out_valid_q;
  logic [bsa_pkg::OutDataW-1:0]  out_data_q;
  bsa_pkg::status_e              out_status_q;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q  <= bsa_pkg::MaxReqRst;
      leak_age_q <= bsa_pkg::LeakAgeRst;
    end else if (cfg_we_i) begin
      unique case (bsa_pkg::cfg_idx_e'(cfg_idx_i))
        bsa_pkg::CFG_MAX_REQ:  max_req_q  <= cfg_wdata_i[bsa_pkg::ReqW-1:0];
        bsa_pkg::CFG_LEAK_AGE: leak_age_q <= cfg_wdata_i[bsa_pkg::AgeW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= bsa_pkg::func_e'(s_axis_tuser_i);
      req_q  <= s_axis_tdata_i[15:0];
      ref_q  <= s_axis_tdata_i[19:16];
      now_q  <= s_axis_tdata_i[51:20];
    end
  end

  bsa_slots #(
    .POOL_SLOTS (POOL_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_slots (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .func_i          (func_q),
    .request_bytes_i (req_q),
    .slot_ref_i      (ref_q),
    .now_ms_i        (now_q),
    .max_req_i       (max_req_q),
    .leak_age_i      (leak_age_q),
    .status_o        (status),
    .granted_slot_o  (granted),
    .leak_map_o      (leak_map),
    .evt_o           (evt)
  );

  bsa_stats #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt),
    .used_d_o     (used_d),
    .peak_d_o     (peak_d),
    .grants_d_o   (grants_d),
    .returns_d_o  (returns_d),
    .refusals_d_o (refusals_d),
    .healthy_o    (healthy)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= step || (out_valid_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_status_q <= status;
      out_data_q   <= {4'b0, leak_map, healthy, refusals_d, returns_d, grants_d,
                       bsa_pkg::UsageW'(peak_d), bsa_pkg::UsageW'(used_d), granted};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  // a word that steps out of the input register always leaves a valid result in the next cycle
  a_step_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid_o)
    else $error("result word missing after step");

  // usage never passes the peak or the pool size
  a_usage_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (used_d <= peak_d) && (32'(used_d) <= 32'(POOL_SLOTS)))
    else $error("usage out of bounds");

  // only a successful allocate reports a slot
  a_grant_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != bsa_pkg::ST_OK)) |-> (m_axis_tdata_o[2:0] == '0))
    else $error("slot reported on failed request");

  // one event at most per word, and none without a step
  a_evt_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(evt) && (step || (evt == '0)))
    else $error("slot events inconsistent");

endmodule

// ----- rtl/core/bsa_slots.sv -----
// bsa_slots: slot used bits, time stamps, lowest-free pick, release check, leak map
// depends on bsa_pkg
module bsa_slots #(
  parameter int unsigned POOL_SLOTS = bsa_pkg::SlotsDef,
  parameter int unsigned TIME_BITS  = bsa_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  bsa_pkg::func_e                func_i,
  input  logic [bsa_pkg::ReqW-1:0]      request_bytes_i,
  input  logic [bsa_pkg::RefW-1:0]      slot_ref_i,
  input  logic [bsa_pkg::NowW-1:0]      now_ms_i,
  input  logic [bsa_pkg::ReqW-1:0]      max_req_i,
  input  logic [bsa_pkg::AgeW-1:0]      leak_age_i,
  output bsa_pkg::status_e              status_o,
  output logic [bsa_pkg::GrantW-1:0]    granted_slot_o,
  output logic [bsa_pkg::LeakW-1:0]     leak_map_o,
  output bsa_pkg::slot_evt_t            evt_o
);

  localparam int unsigned LeakSlots = (POOL_SLOTS < bsa_pkg::LeakW) ? POOL_SLOTS
                                                                     : bsa_pkg::LeakW;
  localparam int unsigned CmpW = (TIME_BITS > bsa_pkg::AgeW) ? TIME_BITS : bsa_pkg::AgeW;

  logic [POOL_SLOTS-1:0] used_q, used_d;
  logic [TIME_BITS-1:0]  stamp_q [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] free, grant_oh, new_oh, hit;
  logic [TIME_BITS-1:0]  now_t;
  logic                  too_large, has_free, in_pool, is_used;
  logic [bsa_pkg::GrantW-1:0] gidx;
  bsa_pkg::slot_evt_t    evt;

  assign now_t     = TIME_BITS'(now_ms_i);
  assign free      = ~used_q;
  // lowest set bit of the free mask
  assign grant_oh  = free & (~free + POOL_SLOTS'(1));
  assign has_free  = |free;
  assign too_large = request_bytes_i > max_req_i;

  always_comb begin
    hit  = '0;
    gidx = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      hit[i] = (32'(slot_ref_i) == 32'(i));
      if (grant_oh[i]) begin
        gidx = gidx | bsa_pkg::GrantW'(i);
      end
    end
  end

  assign in_pool = |hit;
  assign is_used = |(hit & used_q);

  always_comb begin
    status_o       = bsa_pkg::ST_OK;
    evt            = '0;
    used_d         = used_q;
    granted_slot_o = '0;
    if (func_i == bsa_pkg::FUNC_ALLOC) begin
      if (too_large) begin
        status_o   = bsa_pkg::ST_TOO_LARGE;
        evt.refuse = 1'b1;
      end else if (!has_free) begin
        status_o   = bsa_pkg::ST_NO_FREE;
        evt.refuse = 1'b1;
      end else begin
        evt.alloc_ok   = 1'b1;
        used_d         = used_q | grant_oh;
        granted_slot_o = gidx;
      end
    end else begin
      if (!in_pool) begin
        status_o = bsa_pkg::ST_NOT_FOUND;
      end else if (!is_used) begin
        status_o = bsa_pkg::ST_RELEASED;
      end else begin
        evt.release_ok = 1'b1;
        used_d         = used_q & ~hit;
      end
    end
  end

  assign new_oh = evt.alloc_ok ? grant_oh : '0;
  assign evt_o  = step_i ? evt : '0;

  // a freshly stamped slot has age zero and never shows as a leak
  always_comb begin
    logic [TIME_BITS-1:0] age;
    leak_map_o = '0;
    age        = '0;
    for (int i = 0; i < LeakSlots; i++) begin
      age = now_t - stamp_q[i];
      leak_map_o[i] = used_d[i] && !new_oh[i] && (CmpW'(age) > CmpW'(leak_age_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (step_i) begin
      used_q <= used_d;
    end
  end

  // stamps of free slots are never read, so they need no reset or clear
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (step_i && new_oh[i]) begin
        stamp_q[i] <= now_t;
      end
    end
  end

endmodule

// ----- rtl/core/bsa_stats.sv -----
// bsa_stats: usage, peak usage, wrapping counters and health flag
// depends on bsa_pkg
module bsa_stats #(
  parameter int unsigned POOL_SLOTS = bsa_pkg::SlotsDef,
  localparam int unsigned UseW      = $clog2(POOL_SLOTS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bsa_pkg::slot_evt_t         evt_i,
  output logic [UseW-1:0]            used_d_o,
  output logic [UseW-1:0]            peak_d_o,
  output logic [bsa_pkg::CntW-1:0]   grants_d_o,
  output logic [bsa_pkg::CntW-1:0]   returns_d_o,
  output logic [bsa_pkg::CntW-1:0]   refusals_d_o,
  output logic                       healthy_o
);

  localparam int unsigned HlW = UseW + 3 + 8;
  localparam int unsigned FlW = bsa_pkg::CntW + 4;

  logic [UseW-1:0]          used_q, peak_q;
  logic [bsa_pkg::CntW-1:0] grants_q, returns_q, refusals_q;
  logic [HlW-1:0]           use_x5;
  logic [FlW-1:0]           fail_x10;

  always_comb begin
    used_d_o = used_q;
    if (evt_i.alloc_ok) begin
      used_d_o = used_q + UseW'(1);
    end else if (evt_i.release_ok && (used_q != '0)) begin
      used_d_o = used_q - UseW'(1);
    end
  end

  assign peak_d_o     = (used_d_o > peak_q) ? used_d_o : peak_q;
  assign grants_d_o   = grants_q + bsa_pkg::CntW'(evt_i.alloc_ok);
  assign returns_d_o  = returns_q + bsa_pkg::CntW'(evt_i.release_ok);
  assign refusals_d_o = refusals_q + bsa_pkg::CntW'(evt_i.refuse);

  // times five and times ten as shift and add
  assign use_x5   = (HlW'(used_d_o) << 2) + HlW'(used_d_o);
  assign fail_x10 = (FlW'(refusals_d_o) << 3) + (FlW'(refusals_d_o) << 1);
  assign healthy_o = !(use_x5 > HlW'(4 * POOL_SLOTS)) && !(fail_x10 > FlW'(grants_d_o));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      peak_q     <= '0;
      grants_q   <= '0;
      returns_q  <= '0;
      refusals_q <= '0;
    end else begin
      used_q     <= used_d_o;
      peak_q     <= peak_d_o;
      grants_q   <= grants_d_o;
      returns_q  <= returns_d_o;
      refusals_q <= refusals_d_o;
    end
  end

endmodule

// ----- tb/slot_pool_checker.sv -----
// slot_pool_checker: watches the config port and both stream channels of the slot allocator,
// predicts every result word from its own copy of the pool and compares field by field
// depends on bsa_pkg for widths, status codes, function codes and register indexes
module slot_pool_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bsa_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // request_bytes[15:0], slot_ref[19:16], now_ms[51:20], zero pad
  input  logic [bsa_pkg::InDataW-1:0]   s_axis_tdata_i,
  // func[0]
  input  logic                          s_axis_tuser_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // granted_slot[2:0], usage_now[6:3], usage_peak[10:7], alloc_count[42:11],
  // release_count[74:43], failure_count[106:75], healthy[107], leak_map[115:108], zero pad
  input  logic [bsa_pkg::OutDataW-1:0]  m_axis_tdata_i,
  // status[2:0]
  input  logic [bsa_pkg::StatusW-1:0]   m_axis_tuser_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  import bsa_pkg::*;

  localparam int unsigned Slots = SlotsDef;

  typedef struct packed {
    status_e            status;
    logic [GrantW-1:0]  slot;
    logic [UsageW-1:0]  usage;
    logic [UsageW-1:0]  peak;
    logic [CntW-1:0]    grants;
    logic [CntW-1:0]    returns;
    logic [CntW-1:0]    refusals;
    logic               healthy;
    logic [LeakW-1:0]   leaks;
  } pool_report_t;

  logic [ReqW-1:0]    max_bytes;
  logic [AgeW-1:0]    leak_age;
  logic [Slots-1:0]   busy;
  logic [NowW-1:0]    stamp [Slots];
  logic [UsageW-1:0]  in_use;
  logic [UsageW-1:0]  in_use_peak;
  logic [CntW-1:0]    n_grant;
  logic [CntW-1:0]    n_return;
  logic [CntW-1:0]    n_refuse;

  pool_report_t report_q[$];
  int unsigned  n_fail = 0;
  int unsigned  n_pending = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pending;

  task automatic serve_request(input func_e op, input logic [ReqW-1:0] nbytes,
                               input logic [RefW-1:0] sel, input logic [NowW-1:0] now,
                               output pool_report_t r);
    int found;
    logic [NowW-1:0] age;
    r = '0;
    r.status = ST_OK;
    found = -1;
    if (op == FUNC_ALLOC) begin
      if (nbytes > max_bytes) begin
        r.status = ST_TOO_LARGE;
        n_refuse = n_refuse + 1;
      end else begin
        // lowest free slot wins
        for (int i = Slots - 1; i >= 0; i--) begin
          if (!busy[i]) found = i;
        end
        if (found < 0) begin
          r.status = ST_NO_FREE;
          n_refuse = n_refuse + 1;
        end else begin
          busy[found]  = 1'b1;
          stamp[found] = now;
          n_grant      = n_grant + 1;
          in_use       = in_use + UsageW'(1);
          if (in_use > in_use_peak) in_use_peak = in_use;
          r.slot = GrantW'(found);
        end
      end
    end else begin
      if (sel >= Slots) begin
        r.status = ST_NOT_FOUND;
      end else if (!busy[sel]) begin
        r.status = ST_RELEASED;
      end else begin
        busy[sel]  = 1'b0;
        stamp[sel] = '0;
        n_return   = n_return + 1;
        if (in_use > 0) in_use = in_use - UsageW'(1);
      end
    end

    r.usage    = in_use;
    r.peak     = in_use_peak;
    r.grants   = n_grant;
    r.returns  = n_return;
    r.refusals = n_refuse;
    // over 80 percent full, or failures above a tenth of the grants
    r.healthy  = !((int'(in_use) * 5 > int'(Slots) * 4) ||
                   (64'(n_refuse) * 10 > 64'(n_grant)));
    for (int i = 0; i < Slots && i < LeakW; i++) begin
      age = now - stamp[i];
      if (busy[i] && age > leak_age) r.leaks[i] = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_report_t want;
    pool_report_t seen;
    if (!rst_ni) begin
      max_bytes   = MaxReqRst;
      leak_age    = LeakAgeRst;
      busy        = '0;
      for (int i = 0; i < Slots; i++) stamp[i] = '0;
      in_use      = '0;
      in_use_peak = '0;
      n_grant     = '0;
      n_return    = '0;
      n_refuse    = '0;
      report_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_REQ:  max_bytes = cfg_wdata_i[ReqW-1:0];
          CFG_LEAK_AGE: leak_age  = cfg_wdata_i[AgeW-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        serve_request(func_e'(s_axis_tuser_i), s_axis_tdata_i[15:0],
                      s_axis_tdata_i[19:16], s_axis_tdata_i[51:20], want);
        report_q.push_back(want);
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.status   = status_e'(m_axis_tuser_i);
        seen.slot     = m_axis_tdata_i[2:0];
        seen.usage    = m_axis_tdata_i[6:3];
        seen.peak     = m_axis_tdata_i[10:7];
        seen.grants   = m_axis_tdata_i[42:11];
        seen.returns  = m_axis_tdata_i[74:43];
        seen.refusals = m_axis_tdata_i[106:75];
        seen.healthy  = m_axis_tdata_i[107];
        seen.leaks    = m_axis_tdata_i[115:108];
        if (report_q.size() == 0) begin
          $error("result word with no request outstanding");
          n_fail++;
        end else begin
          want = report_q.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tuser_i));
          check_field("granted_slot", 32'(want.slot), 32'(seen.slot));
          check_field("usage_now", 32'(want.usage), 32'(seen.usage));
          check_field("usage_peak", 32'(want.peak), 32'(seen.peak));
          check_field("alloc_count", want.grants, seen.grants);
          check_field("release_count", want.returns, seen.returns);
          check_field("failure_count", want.refusals, seen.refusals);
          check_field("healthy", 32'(want.healthy), 32'(seen.healthy));
          check_field("leak_map", 32'(want.leaks), 32'(seen.leaks));
        end
      end
      n_pending = report_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// tb: top of the slot allocator testbench; drives requests, config writes and output stalls
// depends on bsa_pkg, buffer_slot_allocator_top and slot_pool_checker
module tb;
  import bsa_pkg::*;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx     = CFG_MAX_REQ;
  logic [CfgW-1:0]      cfg_wdata   = '0;
  logic                 s_tvalid    = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata     = '0;
  logic                 s_tuser     = FUNC_ALLOC;
  logic                 m_tvalid;
  logic                 m_tready    = 1'b1;
  logic [OutDataW-1:0]  m_tdata;
  logic [StatusW-1:0]   m_tuser;

  int unsigned          fail_count;
  int unsigned          pending;

  int unsigned          idle_pct     = 0;
  int unsigned          stall_pct    = 0;
  logic                 hold_pending = 1'b0;
  int unsigned          hold_left    = 0;
  logic [ReqW-1:0]      max_bytes    = MaxReqRst;
  logic [NowW-1:0]      clock_ms     = '0;

  buffer_slot_allocator_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  slot_pool_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: errors");
    $finish;
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 80;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // called at a clock edge, returns at the edge where the word is taken
  task automatic send_request(input func_e op, input logic [ReqW-1:0] nbytes,
                              input logic [RefW-1:0] sel, input logic [NowW-1:0] now);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, now, sel, nbytes};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // pipeline is two deep; waits until the checker has no word in flight
  task automatic drain_pool();
    s_tvalid <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [ReqW-1:0] bytes_lim, input logic [AgeW-1:0] age_lim);
    // upper bits of the size register write are junk on purpose
    write_reg(CFG_MAX_REQ, {16'($urandom()), bytes_lim});
    write_reg(CFG_LEAK_AGE, age_lim);
    cfg_we    <= 1'b0;
    max_bytes = bytes_lim;
  endtask

  task automatic request_burst(input int unsigned count, input int unsigned alloc_pct,
                               input int unsigned step_max);
    func_e           op;
    logic [ReqW-1:0] nbytes;
    logic [RefW-1:0] sel;
    int unsigned     pick;
    for (int unsigned n = 0; n < count; n++) begin
      op = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_RELEASE;
      pick = $urandom_range(99);
      if (pick < 70) begin
        nbytes = 16'($urandom_range(32'(max_bytes)));
      end else if (pick < 85) begin
        nbytes = 16'($urandom_range(65535));
      end else begin
        case ($urandom_range(3))
          0:       nbytes = '0;
          1:       nbytes = max_bytes;
          2:       nbytes = max_bytes + 16'd1;
          default: nbytes = '1;
        endcase
      end
      sel = ($urandom_range(99) < 90) ? 4'($urandom_range(7)) : 4'($urandom_range(15, 8));
      clock_ms = clock_ms + $urandom_range(step_max);
      if ($urandom_range(99) == 0) clock_ms = $urandom();
      send_request(op, nbytes, sel, clock_ms);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: size limits, bad and double releases, full pool, time wrap
    send_request(FUNC_ALLOC,   16'd0,     4'd0,  32'd0);
    send_request(FUNC_ALLOC,   16'd2048,  4'd0,  32'd1);
    send_request(FUNC_ALLOC,   16'd2049,  4'd0,  32'd2);
    send_request(FUNC_ALLOC,   16'hFFFF,  4'd0,  32'd3);
    send_request(FUNC_RELEASE, 16'd0,     4'd15, 32'd4);
    send_request(FUNC_RELEASE, 16'hFFFF,  4'd8,  32'd5);
    send_request(FUNC_RELEASE, 16'd0,     4'd5,  32'd6);
    send_request(FUNC_RELEASE, 16'd0,     4'd0,  32'd40000);
    for (int i = 0; i < 7; i++) begin
      send_request(FUNC_ALLOC, 16'(i * 300), 4'd0, 32'hFFFF_FFF0 + i);
    end
    send_request(FUNC_ALLOC,   16'd100,   4'd0,  32'hFFFF_FFFF);
    send_request(FUNC_RELEASE, 16'd0,     4'd3,  32'h0000_0010);
    send_request(FUNC_RELEASE, 16'd0,     4'd3,  32'h0000_0011);
    send_request(FUNC_RELEASE, 16'd0,     4'd1,  32'h8000_0000);
    send_request(FUNC_RELEASE, 16'd0,     4'd7,  32'hFFFF_FFFF);
    drain_pool();

    clock_ms = 32'd1000;
    set_limits(MaxReqRst, 32'd200);
    request_burst(250, 55, 20);
    drain_pool();

    idle_pct = 62;
    set_limits('0, '0);
    request_burst(150, 60, 5);
    drain_pool();

    idle_pct  = 0;
    stall_pct = 62;
    set_limits('1, '1);
    request_burst(250, 50, 1000);
    drain_pool();

    idle_pct  = 10;
    stall_pct = 10;
    set_limits(16'($urandom()), 32'($urandom_range(1000)));
    request_burst(250, 55, 50);
    drain_pool();

    // long output hold-off while requests keep coming
    idle_pct     = 0;
    stall_pct    = 0;
    hold_pending = 1'b1;
    request_burst(60, 50, 20);
    drain_pool();

    set_limits(MaxReqRst, LeakAgeRst);
    for (int i = 0; i < 6; i++) begin
      request_burst(50, (i % 2 == 0) ? 75 : 30, 3000);
    end
    drain_pool();

    idle_pct  = 62;
    stall_pct = 62;
    set_limits(16'($urandom_range(4096)), 32'($urandom()));
    request_burst(200, 55, 100);
    drain_pool();

    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
